// File: rtl/rtnc_pkg.sv
`default_nettype none

package rtnc_pkg;

	localparam int unsigned KIND_W       = 2;
	localparam int unsigned KEY_W        = 30;
	localparam int unsigned ID_W         = 10;
	localparam int unsigned IDX_W        = 10;
	localparam int unsigned OUT_W        = 10;
	localparam int unsigned PL_W         = 8;
	localparam int unsigned MAX_KEYS_DEF = 1024;

	// Prefix lengths are counted as if keys and ids were 32 bits wide.
	localparam int unsigned KEY_PAD = 32 - KEY_W;
	localparam int unsigned ID_BASE = 32 + (32 - ID_W);

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		logic [OUT_W-1:0] range_first;
		logic [OUT_W-1:0] range_last;
		logic [OUT_W-1:0] left_child;
		logic             left_is_leaf;
		logic [OUT_W-1:0] right_child;
		logic             right_is_leaf;
		logic             error;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} done_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		PH_BASE,
		PH_PLUS,
		PH_MINUS,
		PH_GALLOP,
		PH_BSEARCH,
		PH_LOBASE,
		PH_NODE,
		PH_SPLIT
	} phase_t;

endpackage

`default_nettype wire

// File: rtl/rtnc_if.sv
`default_nettype none

interface rtnc_cmd_if import rtnc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic [ID_W-1:0]   prim_id;
	logic [IDX_W-1:0]  node_index;

	modport source (output valid, kind, key, prim_id, node_index, input ready);
	modport sink   (input valid, kind, key, prim_id, node_index, output ready);
endinterface

interface rtnc_rsp_if import rtnc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] range_first;
	logic [OUT_W-1:0] range_last;
	logic [OUT_W-1:0] left_child;
	logic             left_is_leaf;
	logic [OUT_W-1:0] right_child;
	logic             right_is_leaf;
	logic             error;

	modport source (output valid, range_first, range_last, left_child, left_is_leaf,
		right_child, right_is_leaf, error, input ready);
	modport sink   (input valid, range_first, range_last, left_child, left_is_leaf,
		right_child, right_is_leaf, error, output ready);
endinterface

`default_nettype wire

// File: rtl/rtnc_ram.sv
`default_nettype none

module rtnc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/rtnc_plen.sv
`default_nettype none

// Common-prefix length of two stored entries; -1 when the probed entry lies outside the store.
module rtnc_plen import rtnc_pkg::*; (
	input  entry_t                 a,
	input  entry_t                 b,
	input  logic                   hit,
	output logic signed [PL_W-1:0] plen
);

	function automatic logic [5:0] lz_key(input logic [KEY_W-1:0] x);
		logic [5:0] n;
		n = 6'(KEY_W);
		for (int k = 0; k < KEY_W; k++) begin
			if (x[k]) begin
				n = 6'(KEY_W - 1 - k);
			end
		end
		return n;
	endfunction

	function automatic logic [3:0] lz_id(input logic [ID_W-1:0] x);
		logic [3:0] n;
		n = 4'(ID_W);
		for (int k = 0; k < ID_W; k++) begin
			if (x[k]) begin
				n = 4'(ID_W - 1 - k);
			end
		end
		return n;
	endfunction

	logic [KEY_W-1:0] key_x;
	logic [ID_W-1:0]  id_x;

	always_comb begin
		key_x = a.key ^ b.key;
		id_x  = a.id ^ b.id;
		if (!hit) begin
			plen = -PL_W'(1);
		end else if (key_x == '0) begin
			plen = PL_W'(ID_BASE) + PL_W'(lz_id(id_x));
		end else begin
			plen = PL_W'(KEY_PAD) + PL_W'(lz_key(key_x));
		end
	end

endmodule

`default_nettype wire

// File: rtl/rtnc_ctrl.sv
`default_nettype none

module rtnc_ctrl import rtnc_pkg::*; #(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	rtnc_cmd_if.sink       cmd,
	input  logic           take,
	output done_t          done
);

	localparam int unsigned POS_W = $clog2(MAX_KEYS);
	localparam int unsigned CW    = POS_W + 1;
	localparam int unsigned PW    = POS_W + 3;
	localparam int unsigned IW    = (CW > IDX_W) ? CW : IDX_W;

	function automatic logic signed [PW-1:0] offs(input logic signed [PW-1:0] base,
		input logic [PW-1:0] mag, input logic up);
		return up ? base + $signed(mag) : base - $signed(mag);
	endfunction

	state_t state_q, state_nxt;
	phase_t phase_q, phase_nxt;
	logic [CW-1:0] cnt_q;
	logic          err_q;

	logic signed [PW-1:0]   node_q, pos_q, pos_nxt;
	logic                   inr_s1;
	entry_t                 base_q;
	logic                   dplus_q;
	logic signed [PL_W-1:0] pplus_q, floor_q, nlen_q;
	logic [PW-1:0]          reach_q, len_q, t_q;
	logic [POS_W-1:0]       lo_q, hi_q, split_q;
	logic [CW-1:0]          step_q;

	logic                   is_load, is_query, is_clear;
	logic                   cmd_acc, full, node_err, pos_inr;
	logic                   ram_we, ram_re;
	entry_t                 wr_entry, rd_entry;
	logic signed [PL_W-1:0] plen;

	logic                   gt_floor, d_new, split_take, eval_done;
	logic [PW-1:0]          len_new, t_new, reach_new;
	logic signed [PW-1:0]   other;
	logic [POS_W-1:0]       lo_new, hi_new, split_new;
	logic [CW-1:0]          step_first, step_new, split_inc;

	rtnc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_KEYS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[POS_W-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (pos_q[POS_W-1:0]),
		.rdata (rd_entry)
	);

	rtnc_plen u_plen (
		.a    (base_q),
		.b    (rd_entry),
		.hit  (inr_s1),
		.plen (plen)
	);

	always_comb begin
		is_load  = 1'b0;
		is_query = 1'b0;
		is_clear = 1'b0;
		unique case (cmd.kind)
			KIND_LOAD:  is_load  = 1'b1;
			KIND_QUERY: is_query = 1'b1;
			KIND_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
	end

	assign cmd_acc  = cmd.valid && cmd.ready;
	assign full     = cnt_q >= CW'(MAX_KEYS);
	assign ram_we   = cmd_acc && is_load && !full;
	assign wr_entry = '{key: cmd.key, id: cmd.prim_id};
	assign node_err = (cnt_q < CW'(2)) || (IW'(cmd.node_index) >= IW'(cnt_q) - IW'(1));
	assign pos_inr  = !pos_q[PW-1] && (pos_q < $signed(PW'(cnt_q)));

	// Search arithmetic for the probe whose prefix length arrives this cycle.
	always_comb begin
		gt_floor   = plen > floor_q;
		d_new      = pplus_q > plen;
		reach_new  = reach_q << 1;
		len_new    = gt_floor ? len_q + t_q : len_q;
		t_new      = t_q >> 1;
		other      = offs(node_q, len_new, dplus_q);
		if (other < node_q) begin
			lo_new = other[POS_W-1:0];
			hi_new = node_q[POS_W-1:0];
		end else begin
			lo_new = node_q[POS_W-1:0];
			hi_new = other[POS_W-1:0];
		end
		step_first = (CW'(hi_q) - CW'(lo_q) + CW'(1)) >> 1;
		split_take = (pos_q < $signed(PW'(hi_q))) && (plen > nlen_q);
		split_new  = split_take ? pos_q[POS_W-1:0] : split_q;
		step_new   = (step_q + CW'(1)) >> 1;
		split_inc  = CW'(split_q) + CW'(1);

		eval_done = 1'b0;
		pos_nxt   = pos_q;
		phase_nxt = phase_q;
		case (phase_q)
			PH_BASE: begin
				pos_nxt   = offs(node_q, PW'(1), 1'b1);
				phase_nxt = PH_PLUS;
			end
			PH_PLUS: begin
				pos_nxt   = offs(node_q, PW'(1), 1'b0);
				phase_nxt = PH_MINUS;
			end
			PH_MINUS: begin
				pos_nxt   = offs(node_q, PW'(2), d_new);
				phase_nxt = PH_GALLOP;
			end
			PH_GALLOP: begin
				if (gt_floor) begin
					pos_nxt = offs(node_q, reach_new, dplus_q);
				end else begin
					pos_nxt   = offs(node_q, reach_q >> 1, dplus_q);
					phase_nxt = PH_BSEARCH;
				end
			end
			PH_BSEARCH: begin
				if (t_new != '0) begin
					pos_nxt = offs(node_q, len_new + t_new, dplus_q);
				end else begin
					pos_nxt   = $signed(PW'(lo_new));
					phase_nxt = PH_LOBASE;
					eval_done = lo_new == hi_new;
				end
			end
			PH_LOBASE: begin
				pos_nxt   = $signed(PW'(hi_q));
				phase_nxt = PH_NODE;
			end
			PH_NODE: begin
				pos_nxt   = $signed(PW'(lo_q) + PW'(step_first));
				phase_nxt = PH_SPLIT;
			end
			PH_SPLIT: begin
				pos_nxt   = $signed(PW'(split_new) + PW'(step_new));
				eval_done = step_q <= CW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && is_query) begin
					state_nxt = node_err ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_nxt = ST_EVAL;
			ST_EVAL: state_nxt = eval_done ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (take) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready  = state_q == ST_IDLE;
		ram_re     = (state_q == ST_READ) && pos_inr;
		done.valid = state_q == ST_DONE;
		done.res   = '0;
		done.res.error = err_q;
		if (!err_q) begin
			done.res.range_first   = OUT_W'(lo_q);
			done.res.range_last    = OUT_W'(hi_q);
			done.res.left_child    = OUT_W'(split_q);
			done.res.left_is_leaf  = split_q == lo_q;
			done.res.right_child   = OUT_W'(split_inc);
			done.res.right_is_leaf = split_inc == CW'(hi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_BASE;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd_acc) begin
				if (is_clear) begin
					cnt_q <= '0;
				end else if (ram_we) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (is_query) begin
					err_q   <= node_err;
					phase_q <= PH_BASE;
				end
			end
			if (state_q == ST_EVAL) begin
				phase_q <= phase_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc && is_query) begin
			node_q <= $signed(PW'(cmd.node_index));
			pos_q  <= $signed(PW'(cmd.node_index));
		end
		if (state_q == ST_READ) begin
			inr_s1 <= pos_inr;
		end
		if (state_q == ST_EVAL) begin
			pos_q <= pos_nxt;
			case (phase_q)
				PH_BASE:  base_q  <= rd_entry;
				PH_PLUS:  pplus_q <= plen;
				PH_MINUS: begin
					dplus_q <= d_new;
					floor_q <= d_new ? plen : pplus_q;
					reach_q <= PW'(2);
				end
				PH_GALLOP: begin
					if (gt_floor) begin
						reach_q <= reach_new;
					end else begin
						t_q   <= reach_q >> 1;
						len_q <= '0;
					end
				end
				PH_BSEARCH: begin
					len_q <= len_new;
					t_q   <= t_new;
					if (t_new == '0) begin
						lo_q    <= lo_new;
						hi_q    <= hi_new;
						split_q <= lo_new;
					end
				end
				PH_LOBASE: base_q <= rd_entry;
				PH_NODE: begin
					nlen_q  <= plen;
					step_q  <= step_first;
					split_q <= lo_q;
				end
				PH_SPLIT: begin
					split_q <= split_new;
					step_q  <= step_new;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/radix_tree_node_children.sv
// Binary radix tree node builder over keys that arrive already sorted.
// The cmd channel carries three kinds of item. A load appends a key and its primitive id
// to the key memory, a clear empties it, and a query names an internal node. Loads and
// clears give no result; a load into a full memory is dropped.
// Each query gives exactly one item on the rsp channel: the node's key range and its two
// children with leaf flags, or error alone when the node number is not below count - 1.
// A query runs as a sequence of probes, each a memory read plus a prefix compare, done in
// a read state and an eval state because of the registered read port of the single key
// memory. With L the distance between the two ends of the node's range, three probes fix
// the direction, the gallop and the binary search for the far end take floor(log2(L)) + 1
// probes each, and for L above zero two more probes set up the split search, which then
// takes max(1, ceil(log2(L))) probes. A node over two keys takes 8 probes and the root over
// 1024 keys 35. An error query goes from the accept straight to the done state and then
// into the output register, with no probes. Queries are processed one at a time; cmd is
// ready again only once the result has moved into the output register.
// The result sits in an output register; while the receiver stalls, loads and clears
// are still accepted, and a further query finishes its search and then waits until the
// output register frees up. cmd.ready is low while a query is being worked on.
// Reset empties the key memory by clearing the key count; the array is not cleared.
`default_nettype none

module radix_tree_node_children import rtnc_pkg::*; #(
	parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rtnc_cmd_if.sink   cmd,
	rtnc_rsp_if.source rsp
);

	done_t done;
	logic  take;
	logic  rsp_vld_q;
	res_t  rsp_q;

	rtnc_ctrl #(
		.MAX_KEYS(MAX_KEYS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (take),
		.done   (done)
	);

	// The output register takes a new result whenever it is empty or being emptied.
	assign take = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (take) begin
			rsp_vld_q <= done.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && done.valid) begin
			rsp_q <= done.res;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.range_first   = rsp_q.range_first;
	assign rsp.range_last    = rsp_q.range_last;
	assign rsp.left_child    = rsp_q.left_child;
	assign rsp.left_is_leaf  = rsp_q.left_is_leaf;
	assign rsp.right_child   = rsp_q.right_child;
	assign rsp.right_is_leaf = rsp_q.right_is_leaf;
	assign rsp.error         = rsp_q.error;

	// An error result carries nothing but the error flag.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error |-> rsp.range_first == '0 && rsp.range_last == '0 &&
			rsp.left_child == '0 && rsp.right_child == '0 &&
			!rsp.left_is_leaf && !rsp.right_is_leaf)
		else $error("error result with nonzero fields");

	// A finished query that the output register cannot take stays put, unchanged.
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid && !take |=> done.valid && $stable(done.res))
		else $error("finished result lost while output register full");

	// No new item is taken while a finished query waits for the output register.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done.valid |-> !cmd.ready)
		else $error("cmd accepted while a result is pending");

endmodule

`default_nettype wire
